// ----- hdl/tps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tps_pkg;

	localparam int IDX_W   = 3;
	localparam int POS_W   = 2;
	localparam int ST_W    = 2;
	localparam int PWM_W   = 16;
	localparam int TIME_W  = 32;
	localparam int CFG_W   = 16;
	localparam int LIMIT_W = 17;
	localparam int REG_W   = 3;

	// Item kinds.
	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_MOVE = 1'b1;

	// Position codes.
	localparam logic [POS_W-1:0] POS_STRAIGHT = 2'd0;
	localparam logic [POS_W-1:0] POS_DIVERTED = 2'd1;
	localparam logic [POS_W-1:0] POS_UNDET    = 2'd2;
	localparam logic [POS_W-1:0] POS_INCONS   = 2'd3;

	// Status codes.
	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_BLOCKED = 2'd1;
	localparam logic [ST_W-1:0] ST_ERROR   = 2'd2;

	// Register indexes.
	localparam logic [REG_W-1:0] REG_REPORT_PERIOD = 3'd0;
	localparam logic [REG_W-1:0] REG_FALLBACK      = 3'd1;
	localparam logic [REG_W-1:0] REG_MIN_TRAVEL    = 3'd2;
	localparam logic [REG_W-1:0] REG_MAX_TRAVEL    = 3'd3;
	localparam logic [REG_W-1:0] REG_MARGIN        = 3'd4;

	// Register reset values.
	localparam logic [CFG_W-1:0] RST_REPORT_PERIOD = 16'd200;
	localparam logic [CFG_W-1:0] RST_FALLBACK      = 16'd800;
	localparam logic [CFG_W-1:0] RST_MIN_TRAVEL    = 16'd200;
	localparam logic [CFG_W-1:0] RST_MAX_TRAVEL    = 16'd1500;
	localparam logic [CFG_W-1:0] RST_MARGIN        = 16'd200;

	typedef struct packed {
		logic [CFG_W-1:0] report_period;
		logic [CFG_W-1:0] fallback_limit;
		logic [CFG_W-1:0] min_travel;
		logic [CFG_W-1:0] max_travel;
		logic [CFG_W-1:0] margin;
	} cfg_t;

	// What travels down the row of cells with each request.
	typedef struct packed {
		logic               op;
		logic [IDX_W-1:0]   idx;
		logic [POS_W-1:0]   pos;
		logic [TIME_W-1:0]  now;
		logic [LIMIT_W-1:0] limit;
		logic               has_res;
		logic [ST_W-1:0]    status;
		logic               was_change;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [POS_W-1:0] pos;
		logic [ST_W-1:0]  status;
		logic             was_change;
	} result_t;

endpackage

`default_nettype wire

// ----- hdl/tps_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tps_front import tps_pkg::*; #(
	parameter int TURNOUT_COUNT = 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire logic              operation,
	input  wire logic [IDX_W-1:0]  switch_index,
	input  wire logic              straight_level,
	input  wire logic              diverted_level,
	input  wire logic [PWM_W-1:0]  current_pwm,
	input  wire logic [PWM_W-1:0]  target_pwm,
	input  wire logic [TIME_W-1:0] now_ms,
	input  wire cfg_t              cfg,
	output logic                   vld_s1,
	output item_t                  item_s1
);

	logic             in_range;
	logic             s_closed;
	logic             d_closed;
	logic [POS_W-1:0] pos;
	logic [PWM_W-1:0] amp;
	logic [PWM_W-1:0] travel_lo;
	logic [PWM_W-1:0] travel;
	logic [LIMIT_W-1:0] limit;
	item_t            item_d;

	assign in_range = {1'b0, switch_index} < (IDX_W+1)'(TURNOUT_COUNT);
	assign s_closed = ~straight_level;
	assign d_closed = ~diverted_level;

	always_comb begin
		priority if (s_closed && !d_closed) begin
			pos = POS_STRAIGHT;
		end else if (!s_closed && d_closed) begin
			pos = POS_DIVERTED;
		end else if (!s_closed && !d_closed) begin
			pos = POS_UNDET;
		end else begin
			pos = POS_INCONS;
		end
	end

	// Half amplitude, low then high clamp, plus margin; zero pulse: fallback.
	always_comb begin
		amp       = (current_pwm > target_pwm) ? (current_pwm - target_pwm)
		                                       : (target_pwm - current_pwm);
		travel_lo = ({1'b0, amp[PWM_W-1:1]} < cfg.min_travel) ? cfg.min_travel
		                                                      : {1'b0, amp[PWM_W-1:1]};
		travel    = (travel_lo > cfg.max_travel) ? cfg.max_travel : travel_lo;
		if (current_pwm == '0 || target_pwm == '0) begin
			limit = {1'b0, cfg.fallback_limit};
		end else begin
			limit = {1'b0, travel} + {1'b0, cfg.margin};
		end
	end

	always_comb begin
		item_d            = '0;
		item_d.op         = operation;
		item_d.idx        = switch_index;
		item_d.pos        = pos;
		item_d.now        = now_ms;
		item_d.limit      = limit;
		item_d.has_res    = 1'b0;
		item_d.status     = ST_OK;
		item_d.was_change = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= load && in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_d;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/tps_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tps_cell import tps_pkg::*; #(
	parameter int CELL_ID = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [CFG_W-1:0] report_period,
	input  wire logic             in_vld,
	input  wire item_t            in_item,
	output logic                  vld_s2,
	output item_t                 item_s2
);

	// State of the one turnout this cell owns.
	logic [POS_W-1:0]   rep_pos_q;
	logic [ST_W-1:0]    rep_st_q;
	logic [TIME_W-1:0]  last_q;
	logic               armed_q;
	logic [TIME_W-1:0]  start_q;
	logic [LIMIT_W-1:0] limit_q;

	logic              hit;
	logic              is_move;
	logic [TIME_W-1:0] move_elapsed;
	logic [TIME_W-1:0] report_elapsed;
	logic [ST_W-1:0]   st;
	logic              changed;
	logic              periodic;
	logic              report;
	item_t             item_d;

	assign hit            = in_vld && (in_item.idx == IDX_W'(CELL_ID));
	assign is_move        = (in_item.op == OP_MOVE);
	assign move_elapsed   = in_item.now - start_q;
	assign report_elapsed = in_item.now - last_q;

	always_comb begin
		priority if (in_item.pos == POS_UNDET || in_item.pos == POS_INCONS) begin
			st = ST_ERROR;
		end else if (armed_q && (move_elapsed > {{(TIME_W-LIMIT_W){1'b0}}, limit_q})) begin
			st = ST_BLOCKED;
		end else begin
			st = ST_OK;
		end
	end

	assign changed  = (in_item.pos != rep_pos_q) || (st != rep_st_q);
	assign periodic = report_elapsed >= {{(TIME_W-CFG_W){1'b0}}, report_period};
	assign report   = hit && !is_move && (changed || periodic);

	always_comb begin
		item_d = in_item;
		if (report) begin
			item_d.has_res    = 1'b1;
			item_d.status     = st;
			item_d.was_change = changed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_pos_q <= POS_UNDET;
			rep_st_q  <= ST_ERROR;
			last_q    <= '0;
			armed_q   <= 1'b0;
			start_q   <= '0;
			limit_q   <= '0;
		end else if (hit) begin
			if (is_move) begin
				armed_q <= 1'b1;
				start_q <= in_item.now;
				limit_q <= in_item.limit;
			end else begin
				if (st == ST_OK) begin
					armed_q <= 1'b0;
				end
				if (report) begin
					rep_pos_q <= in_item.pos;
					rep_st_q  <= st;
					last_q    <= in_item.now;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		item_s2 <= item_d;
	end

endmodule

`default_nettype wire

// ----- hdl/tps_report_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tps_report_fifo import tps_pkg::*; #(
	parameter int DEPTH = 9
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire result_t                    push_data,
	input  wire logic                       pop_stall,
	output logic                            pop_valid,
	output result_t                         pop_data,
	output logic [$clog2(DEPTH+1)-1:0]      count
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);

	result_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               pop;

	assign pop_valid = (count_q != '0);
	assign pop       = pop_valid && !pop_stall;
	assign pop_data  = mem_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/turnout_position_supervisor_top.sv -----
// Turnout position supervisor: watches up to TURNOUT_COUNT servo-driven turnouts.
// Requests arrive on the item channel (item_valid / item_stall). A movement-start
// request arms one turnout's watchdog; a scan request carries its two active-low
// contacts and the millisecond time, and may produce one report on the report
// channel (report_valid / report_stall). Requests with an index at or above
// TURNOUT_COUNT are dropped without effect.
// One request is accepted per cycle while item_stall is low. Each turnout's
// state lives in its own cell of a row of TURNOUT_COUNT cells; every request
// walks the row, one cell per cycle, and the owning cell updates its state and
// attaches the report, which the end of the row pushes into the output buffer.
// Reports queue in a TURNOUT_COUNT + 3 entry output buffer. While the receiver
// stalls, the row keeps moving; item_stall rises once buffered reports plus
// requests in flight could fill the buffer, so nothing is ever dropped.
// Configuration registers are written through cfg_valid / cfg_ready (always
// ready) and must only change while the block is idle.
// Reset clears all turnouts to undetermined / error with no watchdog armed and
// loads the register defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module turnout_position_supervisor_top import tps_pkg::*; #(
	parameter int TURNOUT_COUNT = 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire logic              operation,
	input  wire logic [IDX_W-1:0]  switch_index,
	input  wire logic              straight_level,
	input  wire logic              diverted_level,
	input  wire logic [PWM_W-1:0]  current_pwm,
	input  wire logic [PWM_W-1:0]  target_pwm,
	input  wire logic [TIME_W-1:0] now_ms,

	output logic                   report_valid,
	input  wire logic              report_stall,
	output logic [IDX_W-1:0]       out_index,
	output logic [POS_W-1:0]       position,
	output logic [ST_W-1:0]        status,
	output logic                   was_change,

	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [REG_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data
);

	// The output buffer must absorb every request in flight plus the one
	// being accepted, with one spare slot so a draining buffer keeps full rate.
	localparam int DEPTH = TURNOUT_COUNT + 3;
	localparam int CNT_W = $clog2(DEPTH+1);
	localparam int INF_W = $clog2(TURNOUT_COUNT+2);
	localparam int SUM_W = $clog2(2*DEPTH+2);

	cfg_t             cfg_q;
	logic             item_accept;
	logic             vld_chain  [TURNOUT_COUNT+1];
	item_t            item_chain [TURNOUT_COUNT+1];
	logic [TURNOUT_COUNT:0] vld_vec;
	logic [INF_W-1:0] inflight_q;
	logic [CNT_W-1:0] fifo_count;
	logic             exit_vld;
	item_t            exit_item;
	logic             push;
	result_t          push_data;
	result_t          pop_data;

	// Configuration registers. The port never pushes back, and indexes
	// past the last register are accepted and ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.report_period  <= RST_REPORT_PERIOD;
			cfg_q.fallback_limit <= RST_FALLBACK;
			cfg_q.min_travel     <= RST_MIN_TRAVEL;
			cfg_q.max_travel     <= RST_MAX_TRAVEL;
			cfg_q.margin         <= RST_MARGIN;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_REPORT_PERIOD: cfg_q.report_period  <= cfg_data;
				REG_FALLBACK:      cfg_q.fallback_limit <= cfg_data;
				REG_MIN_TRAVEL:    cfg_q.min_travel     <= cfg_data;
				REG_MAX_TRAVEL:    cfg_q.max_travel     <= cfg_data;
				REG_MARGIN:        cfg_q.margin         <= cfg_data;
				default:           cfg_q                <= cfg_q;
			endcase
		end
	end

	// Stall is worked out from registers alone, so the receiver's stall
	// never reaches item_stall combinationally.
	assign item_stall  = ({{(SUM_W-CNT_W){1'b0}}, fifo_count} +
	                      {{(SUM_W-INF_W){1'b0}}, inflight_q}) >= SUM_W'(DEPTH);
	assign item_accept = item_valid && !item_stall;

	// Front stage: decodes the contacts and computes the travel limit.
	tps_front #(
		.TURNOUT_COUNT(TURNOUT_COUNT)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (item_accept),
		.operation      (operation),
		.switch_index   (switch_index),
		.straight_level (straight_level),
		.diverted_level (diverted_level),
		.current_pwm    (current_pwm),
		.target_pwm     (target_pwm),
		.now_ms         (now_ms),
		.cfg            (cfg_q),
		.vld_s1         (vld_chain[0]),
		.item_s1        (item_chain[0])
	);

	// The row of cells, one per turnout.
	for (genvar i = 0; i < TURNOUT_COUNT; i++) begin : g_cell
		tps_cell #(
			.CELL_ID(i)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.report_period (cfg_q.report_period),
			.in_vld        (vld_chain[i]),
			.in_item       (item_chain[i]),
			.vld_s2        (vld_chain[i+1]),
			.item_s2       (item_chain[i+1])
		);
	end

	for (genvar i = 0; i <= TURNOUT_COUNT; i++) begin : g_vld
		assign vld_vec[i] = vld_chain[i];
	end

	assign exit_vld  = vld_chain[TURNOUT_COUNT];
	assign exit_item = item_chain[TURNOUT_COUNT];

	// Requests in flight between the front stage and the end of the row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q
			              + INF_W'(item_accept && ({1'b0, switch_index} <
			                                       (IDX_W+1)'(TURNOUT_COUNT)))
			              - INF_W'(exit_vld);
		end
	end

	assign push                 = exit_vld && exit_item.has_res;
	assign push_data.idx        = exit_item.idx;
	assign push_data.pos        = exit_item.pos;
	assign push_data.status     = exit_item.status;
	assign push_data.was_change = exit_item.was_change;

	tps_report_fifo #(
		.DEPTH(DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop_stall (report_stall),
		.pop_valid (report_valid),
		.pop_data  (pop_data),
		.count     (fifo_count)
	);

	assign out_index  = pop_data.idx;
	assign position   = pop_data.pos;
	assign status     = pop_data.status;
	assign was_change = pop_data.was_change;

`ifndef SYNTHESIS
	// The in-flight counter must track the valid bits of the row.
	a_inflight_matches: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == INF_W'($countones(vld_vec)))
		else $error("in-flight count disagrees with valid bits");

	// A report leaving the row always finds room in the buffer.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fifo_count < CNT_W'(DEPTH)))
		else $error("report buffer overflow");

	// Buffered reports plus requests in flight never exceed the buffer depth.
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({{(SUM_W-CNT_W){1'b0}}, fifo_count} + {{(SUM_W-INF_W){1'b0}}, inflight_q})
			<= SUM_W'(DEPTH))
		else $error("credit accounting exceeded buffer depth");

	// A margin write is visible in the next cycle.
	a_cfg_margin: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == REG_MARGIN) |=>
			(cfg_q.margin == $past(cfg_data)))
		else $error("margin register not updated");
`endif

endmodule

`default_nettype wire

// ----- bench/turnout_report_checker.sv -----
`timescale 1ns / 1ps

module turnout_report_checker import tps_pkg::*; #(
	parameter int TURNOUT_COUNT = 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              item_valid,
	input  wire logic              item_stall,
	input  wire logic              operation,
	input  wire logic [IDX_W-1:0]  switch_index,
	input  wire logic              straight_level,
	input  wire logic              diverted_level,
	input  wire logic [PWM_W-1:0]  current_pwm,
	input  wire logic [PWM_W-1:0]  target_pwm,
	input  wire logic [TIME_W-1:0] now_ms,

	input  wire logic              report_valid,
	input  wire logic              report_stall,
	input  wire logic [IDX_W-1:0]  out_index,
	input  wire logic [POS_W-1:0]  position,
	input  wire logic [ST_W-1:0]   status,
	input  wire logic              was_change,

	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic [REG_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,

	output int                     fail_count,
	output int                     pending_reports
);

	logic [CFG_W-1:0]   period_ms;
	logic [CFG_W-1:0]   fallback_ms;
	logic [CFG_W-1:0]   min_ms;
	logic [CFG_W-1:0]   max_ms;
	logic [CFG_W-1:0]   margin_ms;

	logic [POS_W-1:0]   latched_pos [TURNOUT_COUNT];
	logic [ST_W-1:0]    latched_st [TURNOUT_COUNT];
	logic [TIME_W-1:0]  last_report_ms [TURNOUT_COUNT];
	logic               armed [TURNOUT_COUNT];
	logic [TIME_W-1:0]  move_start_ms [TURNOUT_COUNT];
	logic [LIMIT_W-1:0] move_limit_ms [TURNOUT_COUNT];

	result_t            expected_reports [$];
	int                 mismatches;

	function automatic logic [LIMIT_W-1:0] travel_limit_ms(input logic [PWM_W-1:0] cur,
			input logic [PWM_W-1:0] tgt);
		logic [PWM_W-1:0] amp;
		logic [PWM_W-1:0] t;
		if (cur == '0 || tgt == '0) begin
			return {1'b0, fallback_ms};
		end
		amp = (cur > tgt) ? cur - tgt : tgt - cur;
		t = amp >> 1;
		// Lower clamp first, so a crossed pair of bounds lets the upper one win.
		if (t < min_ms) begin
			t = min_ms;
		end
		if (t > max_ms) begin
			t = max_ms;
		end
		return {1'b0, t} + {1'b0, margin_ms};
	endfunction

	function automatic logic [POS_W-1:0] contacts_to_position(input logic sl, input logic dl);
		// Contacts are active low.
		unique case ({sl, dl})
			2'b01:   return POS_STRAIGHT;
			2'b10:   return POS_DIVERTED;
			2'b11:   return POS_UNDET;
			default: return POS_INCONS;
		endcase
	endfunction

	task automatic predict_turnout_item(input logic op, input logic [IDX_W-1:0] idx,
			input logic sl, input logic dl, input logic [PWM_W-1:0] cur,
			input logic [PWM_W-1:0] tgt, input logic [TIME_W-1:0] now);
		logic [POS_W-1:0]  pos;
		logic [ST_W-1:0]   st;
		logic [TIME_W-1:0] moving_for;
		logic [TIME_W-1:0] since_report;
		logic              changed;
		logic              periodic;
		result_t           rep;
		if (int'(idx) >= TURNOUT_COUNT) begin
			return;
		end
		if (op == OP_MOVE) begin
			armed[idx] = 1'b1;
			move_start_ms[idx] = now;
			move_limit_ms[idx] = travel_limit_ms(cur, tgt);
			return;
		end
		pos = contacts_to_position(sl, dl);
		moving_for = now - move_start_ms[idx];
		if (pos == POS_UNDET || pos == POS_INCONS) begin
			st = ST_ERROR;
		end else if (armed[idx] && moving_for > {15'd0, move_limit_ms[idx]}) begin
			st = ST_BLOCKED;
		end else begin
			st = ST_OK;
		end
		changed = (pos != latched_pos[idx]) || (st != latched_st[idx]);
		since_report = now - last_report_ms[idx];
		periodic = since_report >= {16'd0, period_ms};
		if (st == ST_OK) begin
			armed[idx] = 1'b0;
		end
		if (changed || periodic) begin
			latched_pos[idx] = pos;
			latched_st[idx] = st;
			last_report_ms[idx] = now;
			rep.idx = idx;
			rep.pos = pos;
			rep.status = st;
			rep.was_change = changed;
			expected_reports.push_back(rep);
		end
	endtask

	task automatic check_report_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: report field %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			period_ms = RST_REPORT_PERIOD;
			fallback_ms = RST_FALLBACK;
			min_ms = RST_MIN_TRAVEL;
			max_ms = RST_MAX_TRAVEL;
			margin_ms = RST_MARGIN;
			for (int i = 0; i < TURNOUT_COUNT; i++) begin
				latched_pos[i] = POS_UNDET;
				latched_st[i] = ST_ERROR;
				last_report_ms[i] = '0;
				armed[i] = 1'b0;
				move_start_ms[i] = '0;
				move_limit_ms[i] = '0;
			end
			expected_reports.delete();
			mismatches = 0;
			fail_count <= 0;
			pending_reports <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_REPORT_PERIOD: period_ms = cfg_data;
					REG_FALLBACK:      fallback_ms = cfg_data;
					REG_MIN_TRAVEL:    min_ms = cfg_data;
					REG_MAX_TRAVEL:    max_ms = cfg_data;
					REG_MARGIN:        margin_ms = cfg_data;
					default: begin
					end
				endcase
			end
			if (item_valid && !item_stall) begin
				predict_turnout_item(operation, switch_index, straight_level, diverted_level,
					current_pwm, target_pwm, now_ms);
			end
			if (report_valid && !report_stall) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected report turnout %0d position %0d status %0d change %0d",
						$time, out_index, position, status, was_change);
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					check_report_field("out_index", want.idx, out_index);
					check_report_field("position", want.pos, position);
					check_report_field("status", want.status, status);
					check_report_field("was_change", want.was_change, was_change);
				end
			end
			fail_count <= mismatches;
			pending_reports <= expected_reports.size();
		end
	end

endmodule

// ----- bench/turnout_position_supervisor_top_test.sv -----
`timescale 1ns / 1ps

// Bench for the turnout position supervisor. The top only makes requests and
// decides the verdict; a checker beside the block watches all three channels,
// predicts every report and compares it with what the block delivers.
module turnout_position_supervisor_top_test;
	import tps_pkg::*;

	localparam int TURNOUTS       = 6;
	localparam int IDLE_PCT       = 35;
	localparam int PHASE_ITEMS    = 185;
	// Longest stretch without any accepted transfer before the run is abandoned.
	// A correct run never comes close: gaps and stalls are short random bursts.
	localparam int WATCHDOG_LIMIT = 4000;
	// Leaves generous slack for requests that produce no report but are still
	// walking through the row.
	localparam int SETTLE_CYCLES  = 4 * (TURNOUTS + 3);

	localparam logic [IDX_W-1:0] IDX_TOP = 3'd7;
	localparam logic [REG_W-1:0] REG_SPARE_FIRST = REG_MARGIN + 3'd1;
	localparam logic [REG_W-1:0] REG_SPARE_LAST  = 3'd7;

	// Contact levels: the contacts pull their pin low when closed.
	localparam logic CLOSED = 1'b0;
	localparam logic OPEN   = 1'b1;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;

	logic              item_valid = 1'b0;
	logic              item_stall;
	logic              operation = OP_SCAN;
	logic [IDX_W-1:0]  switch_index = '0;
	logic              straight_level = OPEN;
	logic              diverted_level = OPEN;
	logic [PWM_W-1:0]  current_pwm = '0;
	logic [PWM_W-1:0]  target_pwm = '0;
	logic [TIME_W-1:0] now_ms = '0;

	logic              report_valid;
	logic              report_stall = 1'b0;
	logic [IDX_W-1:0]  out_index;
	logic [POS_W-1:0]  position;
	logic [ST_W-1:0]   status;
	logic              was_change;

	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [REG_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;

	int                fails;
	int                pending;

	// When set, neither side idles: used for one long back-to-back stretch.
	logic              steady = 1'b0;
	// Running millisecond time for the well-formed request sequences.
	logic [TIME_W-1:0] clock_ms = '0;
	int                quiet_cycles = 0;

	turnout_position_supervisor_top #(
		.TURNOUT_COUNT(TURNOUTS)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.operation      (operation),
		.switch_index   (switch_index),
		.straight_level (straight_level),
		.diverted_level (diverted_level),
		.current_pwm    (current_pwm),
		.target_pwm     (target_pwm),
		.now_ms         (now_ms),
		.report_valid   (report_valid),
		.report_stall   (report_stall),
		.out_index      (out_index),
		.position       (position),
		.status         (status),
		.was_change     (was_change),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	turnout_report_checker #(
		.TURNOUT_COUNT(TURNOUTS)
	) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.operation       (operation),
		.switch_index    (switch_index),
		.straight_level  (straight_level),
		.diverted_level  (diverted_level),
		.current_pwm     (current_pwm),
		.target_pwm      (target_pwm),
		.now_ms          (now_ms),
		.report_valid    (report_valid),
		.report_stall    (report_stall),
		.out_index       (out_index),
		.position        (position),
		.status          (status),
		.was_change      (was_change),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fails),
		.pending_reports (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The report receiver stalls at random, except during the steady stretch.
	always @(posedge clk) begin
		if (steady) begin
			report_stall <= 1'b0;
		end else begin
			report_stall <= ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Watchdog: any accepted request, report or register write restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (report_valid && !report_stall) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired with %0d reports outstanding", $time, pending);
				$display("Test completed with failures");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Presents one request and returns at the edge where it is accepted. Before
	// the request the sender may idle at random. Valid stays high
	// on return so that back-to-back requests are never split by a glitch.
	task automatic send_item(input logic op, input logic [IDX_W-1:0] idx, input logic sl,
			input logic dl, input logic [PWM_W-1:0] cur, input logic [PWM_W-1:0] tgt,
			input logic [TIME_W-1:0] now);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		operation <= op;
		switch_index <= idx;
		straight_level <= sl;
		diverted_level <= dl;
		current_pwm <= cur;
		target_pwm <= tgt;
		now_ms <= now;
		do @(posedge clk); while (item_stall);
	endtask

	// Stops sending and waits until every predicted report has been delivered,
	// then lets requests that produce no report finish their walk through the row.
	task automatic wait_idle();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last write.
	task automatic write_reg(input logic [REG_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_registers(input logic [CFG_W-1:0] per, input logic [CFG_W-1:0] fb,
			input logic [CFG_W-1:0] mn, input logic [CFG_W-1:0] mx,
			input logic [CFG_W-1:0] mg, input bit spare_too);
		write_reg(REG_REPORT_PERIOD, per);
		write_reg(REG_FALLBACK, fb);
		write_reg(REG_MIN_TRAVEL, mn);
		write_reg(REG_MAX_TRAVEL, mx);
		write_reg(REG_MARGIN, mg);
		// Indexes past the last register must be ignored by the block.
		if (spare_too) begin
			for (int r = int'(REG_SPARE_FIRST); r <= int'(REG_SPARE_LAST); r++) begin
				write_reg(REG_W'(r), CFG_W'($urandom));
			end
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// One random request. Most are well-formed: a movement start or a scan with
	// one contact closed, on the running time, so the watchdog and the periodic
	// re-report are reached. The rest is noise and out-of-range turnouts.
	// counted tells whether the block acts on the request at all.
	task automatic send_random_item(output bit counted);
		int               pick;
		int               r;
		logic [IDX_W-1:0] idx;
		logic             sl;
		logic [PWM_W-1:0] cur;
		logic [PWM_W-1:0] tgt;
		pick = $urandom_range(99);
		r = $urandom_range(99);
		if (r < 85) begin
			clock_ms += TIME_W'($urandom_range(250));
		end else if (r < 95) begin
			clock_ms += TIME_W'($urandom_range(3000));
		end else begin
			// Big jumps also carry the time across its wrap.
			clock_ms += TIME_W'($urandom);
		end
		if (pick < 8) begin
			idx = IDX_W'($urandom_range(7));
			send_item(1'($urandom_range(1)), idx, 1'($urandom_range(1)),
				1'($urandom_range(1)), PWM_W'($urandom), PWM_W'($urandom), TIME_W'($urandom));
			counted = (int'(idx) < TURNOUTS);
		end else if (pick < 12) begin
			idx = IDX_W'($urandom_range(int'(IDX_TOP), TURNOUTS));
			send_item(1'($urandom_range(1)), idx, 1'($urandom_range(1)),
				1'($urandom_range(1)), PWM_W'($urandom), PWM_W'($urandom), clock_ms);
			counted = 1'b0;
		end else if (pick < 32) begin
			idx = IDX_W'($urandom_range(TURNOUTS - 1));
			r = $urandom_range(99);
			if (r < 10) begin
				// One of the two pulse values is zero: the fallback limit applies.
				cur = ($urandom_range(1) == 0) ? '0 : PWM_W'($urandom);
				tgt = (cur == '0) ? PWM_W'($urandom) : '0;
			end else if (r < 80) begin
				cur = PWM_W'($urandom_range(2500, 500));
				tgt = PWM_W'($urandom_range(2500, 500));
			end else begin
				cur = PWM_W'($urandom);
				tgt = PWM_W'($urandom);
			end
			send_item(OP_MOVE, idx, 1'($urandom_range(1)), 1'($urandom_range(1)), cur, tgt,
				clock_ms);
			counted = 1'b1;
		end else begin
			idx = IDX_W'($urandom_range(TURNOUTS - 1));
			if ($urandom_range(99) < 80) begin
				sl = 1'($urandom_range(1));
				send_item(OP_SCAN, idx, sl, ~sl, PWM_W'($urandom), PWM_W'($urandom), clock_ms);
			end else begin
				send_item(OP_SCAN, idx, 1'($urandom_range(1)), 1'($urandom_range(1)),
					PWM_W'($urandom), PWM_W'($urandom), clock_ms);
			end
			counted = 1'b1;
		end
	endtask

	// One register setting followed by a batch of random requests. The block is
	// drained first so that the registers only ever change while it is idle.
	task automatic run_phase(input logic [CFG_W-1:0] per, input logic [CFG_W-1:0] fb,
			input logic [CFG_W-1:0] mn, input logic [CFG_W-1:0] mx,
			input logic [CFG_W-1:0] mg, input bit spare_too, input bit no_idle,
			input bit hold_midway);
		int done;
		bit counted;
		done = 0;
		wait_idle();
		program_registers(per, fb, mn, mx, mg, spare_too);
		steady <= no_idle;
		while (done < PHASE_ITEMS) begin
			send_random_item(counted);
			if (counted) begin
				done++;
			end
			// Once per run the sender holds off until every report is out.
			if (hold_midway && done == PHASE_ITEMS / 2) begin
				wait_idle();
				hold_midway = 1'b0;
			end
		end
		steady <= 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests under the reset register values.
		// First scan leaves the reset state: a change to straight and ok.
		send_item(OP_SCAN, 3'd0, CLOSED, OPEN, 16'd0, 16'd0, 32'd0);
		// Same reading soon after: nothing to report.
		send_item(OP_SCAN, 3'd0, CLOSED, OPEN, 16'd0, 16'd0, 32'd10);
		// Report period reached exactly: periodic re-report.
		send_item(OP_SCAN, 3'd0, CLOSED, OPEN, 16'd0, 16'd0, 32'd200);
		// Zero current pulse: fallback limit; elapsed equal to the limit stays ok.
		send_item(OP_MOVE, 3'd1, OPEN, OPEN, 16'd0, 16'd1500, 32'd1000);
		send_item(OP_SCAN, 3'd1, OPEN, CLOSED, 16'd0, 16'd0, 32'd1800);
		// Computed limit of 700; one past it is blocked.
		send_item(OP_MOVE, 3'd1, OPEN, OPEN, 16'd1000, 16'd2000, 32'd2000);
		send_item(OP_SCAN, 3'd1, OPEN, CLOSED, 16'd0, 16'd0, 32'd2701);
		// Both contacts closed, then neither: error wins over the armed watchdog.
		send_item(OP_SCAN, 3'd1, CLOSED, CLOSED, 16'd0, 16'd0, 32'd2702);
		send_item(OP_SCAN, 3'd1, OPEN, OPEN, 16'd0, 16'd0, 32'd2703);
		// Largest amplitude hits the upper clamp.
		send_item(OP_MOVE, 3'd2, OPEN, OPEN, 16'hFFFF, 16'd1, 32'd5000);
		send_item(OP_SCAN, 3'd2, CLOSED, OPEN, 16'd0, 16'd0, 32'd6701);
		// Still blocked and unchanged: no report.
		send_item(OP_SCAN, 3'd2, CLOSED, OPEN, 16'd0, 16'd0, 32'd6702);
		// Small amplitude hits the lower clamp; the elapsed time wraps around zero.
		send_item(OP_MOVE, 3'd3, OPEN, OPEN, 16'd1000, 16'd1100, 32'hFFFF_FF00);
		send_item(OP_SCAN, 3'd3, OPEN, CLOSED, 16'd0, 16'd0, 32'h0000_0010);
		// Zero target pulse: fallback limit, then blocked and held blocked.
		send_item(OP_MOVE, 3'd4, OPEN, OPEN, 16'd5, 16'd0, 32'd100);
		send_item(OP_SCAN, 3'd4, CLOSED, OPEN, 16'd0, 16'd0, 32'd901);
		send_item(OP_SCAN, 3'd4, CLOSED, OPEN, 16'd0, 16'd0, 32'd902);
		// Last valid turnout with every wide field at its top value.
		send_item(OP_SCAN, 3'd5, OPEN, CLOSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		// Out-of-range turnouts are ignored, whatever the operation.
		send_item(OP_SCAN, 3'd6, CLOSED, OPEN, 16'd0, 16'd0, 32'd0);
		send_item(OP_MOVE, IDX_TOP, OPEN, OPEN, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		// Equal pulses: zero amplitude, lifted to the lower clamp.
		send_item(OP_MOVE, 3'd5, CLOSED, CLOSED, 16'hFFFF, 16'hFFFF, 32'd0);
		send_item(OP_SCAN, 3'd5, OPEN, CLOSED, 16'd0, 16'd0, 32'd1);

		// Register settings: all zero (every scan reported, zero limits), all ones,
		// crossed clamp bounds in a long stretch without idling, a one-millisecond
		// period with the hold-off, two random settings, and the reset values.
		run_phase(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0, 1'b0);
		run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
		run_phase(16'd50, 16'd300, 16'd1000, 16'd100, 16'd50, 1'b0, 1'b1, 1'b0);
		run_phase(16'd1, 16'd100, 16'd0, 16'hFFFF, 16'd0, 1'b0, 1'b0, 1'b1);
		run_phase(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
			CFG_W'($urandom), 1'b0, 1'b0, 1'b0);
		run_phase(CFG_W'($urandom_range(400, 1)), CFG_W'($urandom_range(3000)),
			CFG_W'($urandom_range(1000)), CFG_W'($urandom_range(3000)),
			CFG_W'($urandom_range(500)), 1'b0, 1'b0, 1'b0);
		run_phase(RST_REPORT_PERIOD, RST_FALLBACK, RST_MIN_TRAVEL, RST_MAX_TRAVEL, RST_MARGIN,
			1'b0, 1'b0, 1'b0);

		// Drain, then give any stray report time to show up before the verdict.
		wait_idle();
		@(negedge clk);
		if (fails == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
